@@ rtl/msrt_pkg.sv @@
package msrt_pkg;

  // Table geometry
  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned SLOT_W          = 4;

  // Operation carried by one item
  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Classified item passed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [15:0] metric;
    logic [2:0]  flags;
    logic [3:0]  device;
  } item_t;

  // One stored route
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [15:0] metric;
    logic [2:0]  flags;
    logic [3:0]  device;
  } entry_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [31:0]       gateway;
    logic [15:0]       metric;
    logic [2:0]        flags;
    logic [3:0]        device;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

@@ rtl/mask_sorted_route_table_unit.sv @@
// Route table kept in order of descending mask, with first-match lookup.
//
// Input channel (in_valid_i / in_stall_o): one item per accepted edge.
// func_i = 0 adds the route (address_i, mask_i, gateway_i, metric_i,
// route_flags_i, device_i); func_i = 1 looks up destination address_i.
// Output channel (out_valid_o / out_stall_i): exactly one result item per
// input item, in input order: status_o plus the found_* fields of the hit.
//
// A two-deep input queue takes items while the table engine is busy and
// while a finished result waits in the output register. The engine walks
// the table memory one entry per cycle and works on one item at a time.
// A lookup ends at its first hit, after the last entry on a miss, or with
// no read on an empty table. An add scans for its place, shifts the routes
// below it down and writes the new route; an add to a full table is
// answered with ST_FULL without touching the table. The engine returns to
// idle as a result enters the output register, then takes the next item.
//
// Reset empties the table and the queue at once; no clearing pass runs.
// While out_stall_i is high the result holds, the engine finishes its
// current item and waits, and the input stalls once the queue is full.
module mask_sorted_route_table_unit #(
  parameter int unsigned ENTRIES = msrt_pkg::DEFAULT_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] address_i,
  input  logic [31:0] mask_i,
  input  logic [31:0] gateway_i,
  input  logic [15:0] metric_i,
  input  logic [2:0]  route_flags_i,
  input  logic [3:0]  device_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_gateway_o,
  output logic [15:0] found_metric_o,
  output logic [2:0]  found_flags_o,
  output logic [3:0]  found_device_o,
  output logic [3:0]  found_slot_o
);
  import msrt_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t out_res;

  msrt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .address_i     (address_i),
    .mask_i        (mask_i),
    .gateway_i     (gateway_i),
    .metric_i      (metric_i),
    .route_flags_i (route_flags_i),
    .device_i      (device_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_item_o      (q_item)
  );

  msrt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // Unpack the result item onto the ports
  assign status_o        = out_res.status;
  assign found_gateway_o = out_res.gateway;
  assign found_metric_o  = out_res.metric;
  assign found_flags_o   = out_res.flags;
  assign found_device_o  = out_res.device;
  assign found_slot_o    = out_res.slot;

endmodule

@@ rtl/msrt_ram.sv @@
module msrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one row, read one row with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/msrt_front.sv @@
module msrt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [31:0]         address_i,
  input  logic [31:0]         mask_i,
  input  logic [31:0]         gateway_i,
  input  logic [15:0]         metric_i,
  input  logic [2:0]          route_flags_i,
  input  logic [3:0]          device_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output msrt_pkg::item_t     q_item_o
);
  import msrt_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slot_q [QUEUE_DEPTH];
  logic [QW-1:0]  wptr_q, wptr_d;
  logic [QW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           push;
  logic           pop;
  item_t          new_item;

  // Classify the incoming item
  always_comb begin
    new_item.op      = func_i ? OP_LOOKUP : OP_ADD;
    new_item.address = address_i;
    new_item.mask    = mask_i;
    new_item.gateway = gateway_i;
    new_item.metric  = metric_i;
    new_item.flags   = route_flags_i;
    new_item.device  = device_i;
  end

  assign in_stall_o = (fill_q == CW'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rptr_q];

  // Advance pointers and fill level
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= new_item;
    end
  end

endmodule

@@ rtl/msrt_back.sv @@
module msrt_back #(
  parameter int unsigned ENTRIES = msrt_pkg::DEFAULT_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  msrt_pkg::item_t             q_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msrt_pkg::result_t           out_res_o
);
  import msrt_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_LOOK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  ri_q, ri_d;
  logic           chk_v_q, chk_v_d;
  logic [AW-1:0]  chk_idx_q, chk_idx_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [AW-1:0]  s_q, s_d;
  logic [CW-1:0]  left_q, left_d;
  logic           wv_q, wv_d;
  logic [AW-1:0]  wa_q, wa_d;
  item_t          item_q, item_d;
  result_t        res_q, res_d;
  logic           out_valid_q, out_valid_d;
  result_t        out_q, out_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;
  entry_t         row;
  entry_t         new_entry;
  logic           out_free;
  logic           scan_end;

  msrt_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row      = entry_t'(ram_rdata);
  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_end = (ri_q == cnt_q) && !chk_v_q;

  // Route built from the item being added
  always_comb begin
    new_entry.network = item_q.address;
    new_entry.mask    = item_q.mask;
    new_entry.gateway = item_q.gateway;
    new_entry.metric  = item_q.metric;
    new_entry.flags   = item_q.flags;
    new_entry.device  = item_q.device;
  end

  // Sequence one item: scan, shift and insert, or scan for a match; report a full table
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ri_d        = ri_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    pos_d       = pos_q;
    s_d         = s_q;
    left_d      = left_q;
    wv_d        = 1'b0;
    wa_d        = wa_q;
    item_d      = item_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = row;
    ram_re      = 1'b0;
    ram_raddr   = ri_q[AW-1:0];

    // Drop the output item once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          ri_d    = '0;
          if (q_item_i.op == OP_LOOKUP) begin
            state_d = S_LOOK;
          end else if (cnt_q == CW'(ENTRIES)) begin
            res_d        = '0;
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_FIND;
          end
        end
      end

      S_FIND: begin
        if (chk_v_q && (item_q.mask >= row.mask)) begin
          pos_d   = chk_idx_q;
          left_d  = cnt_q - CW'(chk_idx_q);
          s_d     = AW'(cnt_q - 1'b1);
          state_d = S_SHIFT;
        end else if (scan_end) begin
          pos_d   = AW'(cnt_q);
          left_d  = '0;
          state_d = S_SHIFT;
        end else if (ri_q != cnt_q) begin
          ram_re    = 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = ri_q[AW-1:0];
          ri_d      = ri_q + 1'b1;
        end
      end

      S_SHIFT: begin
        // Move one route down a slot per cycle, deepest first
        if (wv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = row;
        end
        if (left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = s_q;
          wv_d      = 1'b1;
          wa_d      = s_q + 1'b1;
          s_d       = s_q - 1'b1;
          left_d    = left_q - 1'b1;
        end else if (!wv_q) begin
          ram_we       = 1'b1;
          ram_waddr    = pos_q;
          ram_wdata    = new_entry;
          cnt_d        = cnt_q + 1'b1;
          res_d        = '0;
          res_d.status = ST_OK;
          state_d      = S_DONE;
        end
      end

      S_LOOK: begin
        if (chk_v_q && ((row.mask & item_q.address) == (row.mask & row.network))) begin
          res_d.status  = ST_OK;
          res_d.gateway = row.gateway;
          res_d.metric  = row.metric;
          res_d.flags   = row.flags;
          res_d.device  = row.device;
          res_d.slot    = SLOT_W'(chk_idx_q);
          state_d       = S_DONE;
        end else if (scan_end) begin
          res_d        = '0;
          res_d.status = ST_MISS;
          state_d      = S_DONE;
        end else if (ri_q != cnt_q) begin
          ram_re    = 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = ri_q[AW-1:0];
          ri_d      = ri_q + 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ri_q        <= '0;
      chk_v_q     <= 1'b0;
      left_q      <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ri_q        <= ri_d;
      chk_v_q     <= chk_v_d;
      left_q      <= left_d;
      wv_q        <= wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload of the item in work and its result
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    pos_q     <= pos_d;
    s_q       <= s_d;
    wa_q      <= wa_d;
    item_q    <= item_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import msrt_pkg::*;

  localparam int unsigned TABLE_SIZE   = DEFAULT_ENTRIES;
  localparam int          CLK_PERIOD   = 10;
  localparam int          RANDOM_ITEMS = 1725;
  localparam int          HOLD_AFTER   = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          PRINT_LIMIT  = 40;

  // One row of the directed stimulus
  typedef struct {
    item_t   it;
    bit      typed;
    status_e want;
  } route_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        func_i;
  logic [31:0] address_i;
  logic [31:0] mask_i;
  logic [31:0] gateway_i;
  logic [15:0] metric_i;
  logic [2:0]  route_flags_i;
  logic [3:0]  device_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [31:0] found_gateway_o;
  logic [15:0] found_metric_o;
  logic [2:0]  found_flags_o;
  logic [3:0]  found_device_o;
  logic [3:0]  found_slot_o;

  // Shadow route table, kept in descending mask order
  entry_t     route_tab [TABLE_SIZE];
  int         route_count = 0;
  result_t    route_results [$];
  route_row_t route_rows [$];
  result_t    due;
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;

  mask_sorted_route_table_unit #(
    .ENTRIES(TABLE_SIZE)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .address_i      (address_i),
    .mask_i         (mask_i),
    .gateway_i      (gateway_i),
    .metric_i       (metric_i),
    .route_flags_i  (route_flags_i),
    .device_i       (device_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_gateway_o(found_gateway_o),
    .found_metric_o (found_metric_o),
    .found_flags_o  (found_flags_o),
    .found_device_o (found_device_o),
    .found_slot_o   (found_slot_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Apply an add or a lookup to the shadow table and return the route result
  function automatic result_t resolve_route(input item_t it);
    result_t res;
    int      i;
    int      pos;
    bit      hit;
    res = '0;
    hit = 1'b0;
    if (it.op == OP_ADD) begin
      if (route_count >= TABLE_SIZE) begin
        res.status = ST_FULL;
      end else begin
        // find the first route whose mask is not above the new one
        pos = route_count;
        for (i = 0; i < route_count; i++) begin
          if (!hit && it.mask >= route_tab[i].mask) begin
            pos = i;
            hit = 1'b1;
          end
        end
        for (i = route_count; i > pos; i--) begin
          route_tab[i] = route_tab[i - 1];
        end
        route_tab[pos].network = it.address;
        route_tab[pos].mask    = it.mask;
        route_tab[pos].gateway = it.gateway;
        route_tab[pos].metric  = it.metric;
        route_tab[pos].flags   = it.flags;
        route_tab[pos].device  = it.device;
        route_count++;
        res.status = ST_OK;
      end
    end else begin
      // first route in table order whose masked network matches
      res.status = ST_MISS;
      for (i = 0; i < route_count; i++) begin
        if (!hit && (route_tab[i].mask & it.address) ==
            (route_tab[i].mask & route_tab[i].network)) begin
          hit          = 1'b1;
          res.status   = ST_OK;
          res.gateway  = route_tab[i].gateway;
          res.metric   = route_tab[i].metric;
          res.flags    = route_tab[i].flags;
          res.device   = route_tab[i].device;
          res.slot     = i[SLOT_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Draw a random item; most lookups aim inside a stored route
  function automatic item_t random_route_item();
    item_t it;
    int    pick;
    int    k;
    it.address = $urandom();
    it.mask    = $urandom();
    it.gateway = $urandom();
    it.metric  = 16'($urandom_range(0, 16'hFFFF));
    it.flags   = 3'($urandom_range(0, 7));
    it.device  = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.op = OP_ADD;
    end else begin
      it.op = OP_LOOKUP;
      if (pick < 80 && route_count > 0) begin
        k = $urandom_range(0, route_count - 1);
        it.address = (route_tab[k].network & route_tab[k].mask) |
                     (it.address & ~route_tab[k].mask);
      end
    end
    return it;
  endfunction

  task automatic table_row(input op_e op, input logic [31:0] address,
                           input logic [31:0] mask, input logic [31:0] gateway,
                           input logic [15:0] metric, input logic [2:0] flags,
                           input logic [3:0] device, input bit typed,
                           input status_e want);
    route_row_t row;
    row.it.op      = op;
    row.it.address = address;
    row.it.mask    = mask;
    row.it.gateway = gateway;
    row.it.metric  = metric;
    row.it.flags   = flags;
    row.it.device  = device;
    row.typed      = typed;
    row.want       = want;
    route_rows.push_back(row);
  endtask

  // Offer one item, wait for it to be taken, then queue its expected result
  task automatic push_item(input item_t it, input bit typed, input status_e want);
    result_t predicted;
    result_t fixed;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 40)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    func_i        <= it.op;
    address_i     <= it.address;
    mask_i        <= it.mask;
    gateway_i     <= it.gateway;
    metric_i      <= it.metric;
    route_flags_i <= it.flags;
    device_i      <= it.device;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    items_sent++;
    burst_left--;
    predicted = resolve_route(it);
    if (typed) begin
      fixed = '0;
      fixed.status = want;
      route_results.push_back(fixed);
    end else begin
      route_results.push_back(predicted);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (route_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        due = route_results.pop_front();
        if (status_o !== due.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_seen, status_o, due.status));
        if (found_gateway_o !== due.gateway)
          report_mismatch($sformatf("result %0d gateway %h, want %h",
                                    results_seen, found_gateway_o, due.gateway));
        if (found_metric_o !== due.metric)
          report_mismatch($sformatf("result %0d metric %h, want %h",
                                    results_seen, found_metric_o, due.metric));
        if (found_flags_o !== due.flags)
          report_mismatch($sformatf("result %0d flags %0d, want %0d",
                                    results_seen, found_flags_o, due.flags));
        if (found_device_o !== due.device)
          report_mismatch($sformatf("result %0d device %0d, want %0d",
                                    results_seen, found_device_o, due.device));
        if (found_slot_o !== due.slot)
          report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                    results_seen, found_slot_o, due.slot));
      end
      results_seen++;
    end
  end

  // Receiver: stall in stretches of varying density, and hold off once for long
  initial begin
    int mode;
    int span;
    int k;
    bit held_long;
    held_long   = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held_long && items_sent >= HOLD_AFTER) begin
        held_long = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(10, 150);
        for (k = 0; k < span; k++) begin
          @(posedge clk_i);
          case (mode)
            0, 1, 2, 3: out_stall_i <= 1'b0;
            4, 5, 6:    out_stall_i <= ($urandom_range(0, 3) == 0);
            7, 8:       out_stall_i <= ($urandom_range(0, 3) != 0);
            default:    out_stall_i <= (k % 3 == 0);
          endcase
        end
      end
    end
  end

  // Sender: reset, directed rows, random items, then drain
  initial begin
    int n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = OP_ADD;
    address_i     = '0;
    mask_i        = '0;
    gateway_i     = '0;
    metric_i      = '0;
    route_flags_i = '0;
    device_i      = '0;

    // lookup on an empty table
    table_row(OP_LOOKUP, 32'h0A00_0001, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b1, ST_MISS);
    table_row(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 16'h000A, 3'd0, 4'd1,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0000_0000, 16'hFFFF, 3'd7, 4'd15,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 3'd1, 4'd0,
              1'b1, ST_OK);
    table_row(OP_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    table_row(OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    table_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    table_row(OP_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    // equal mask: the newer route goes in front
    table_row(OP_ADD, 32'h0A01_0000, 32'hFF00_0000, 32'h0A01_00FE, 16'h0014, 3'd2, 4'd2,
              1'b1, ST_OK);
    table_row(OP_LOOKUP, 32'h0A99_9999, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    table_row(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 16'h8000, 3'd4, 4'd8,
              1'b1, ST_OK);
    // non-contiguous mask
    table_row(OP_ADD, 32'h00F0_00F0, 32'h00F0_F0F0, 32'h8765_4321, 16'h1234, 3'd3, 4'd5,
              1'b1, ST_OK);
    table_row(OP_LOOKUP, 32'h8000_0001, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    table_row(OP_LOOKUP, 32'h12F0_05F7, 32'h0, 32'h0, 16'h0, 3'd0, 4'd0, 1'b0, ST_OK);
    // fill the rest of the table
    table_row(OP_ADD, 32'hAC10_0000, 32'hFFF0_0000, 32'hAC10_00FE, 16'h0100, 3'd0, 4'd3,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'hC0A8_0104, 32'hFFFF_FFFC, 32'hC0A8_0101, 16'h0001, 3'd1, 4'd4,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h0102_0304, 32'hFFFF_FFFF, 32'h0102_0301, 16'h0002, 3'd5, 4'd6,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h0000_0003, 32'h0000_0003, 32'h0000_0000, 16'h0003, 3'd6, 4'd7,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'hF000_0000, 32'hF000_0000, 32'hF000_00FE, 16'h0004, 3'd2, 4'd9,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'hC0A8_0000, 32'hFFFF_F000, 32'hC0A8_00FE, 16'h0005, 3'd0, 4'd10,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h6440_0000, 32'hFFC0_0000, 32'h6440_0001, 16'h0006, 3'd4, 4'd11,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h0000_ABCD, 32'h0000_FFFF, 32'h0000_AB01, 16'h0007, 3'd7, 4'd12,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h0A00_0A00, 32'hFF00_FF00, 32'h0A00_0A01, 16'h0008, 3'd3, 4'd13,
              1'b1, ST_OK);
    table_row(OP_ADD, 32'h1234_5678, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0009, 3'd1, 4'd14,
              1'b1, ST_OK);
    // add to a full table
    table_row(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 4'd15,
              1'b1, ST_FULL);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < route_rows.size(); n++) push_item(route_rows[n].it, route_rows[n].typed,
                                                      route_rows[n].want);
    for (n = 0; n < RANDOM_ITEMS; n++) push_item(random_route_item(), 1'b0, ST_OK);
    in_valid_i <= 1'b0;

    // drain outstanding results, then watch for strays
    while (route_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
